>>> rtl/core/chunked_fixed_block_allocator_assert.svh
// assertion macros for the block allocator
`ifndef CHUNKED_FIXED_BLOCK_ALLOCATOR_ASSERT_SVH
`define CHUNKED_FIXED_BLOCK_ALLOCATOR_ASSERT_SVH
// implication checked on every edge out of reset
`define CFBA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define CFBA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> rtl/core/cfba_pkg.sv
// ----------------------------------------------------------------------------
// cfba_pkg
// status codes and operation codes of the block allocator
// ----------------------------------------------------------------------------
package cfba_pkg;
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_SPACE   = 2'd1;
  localparam logic [1:0] ST_BAD_OFFSET = 2'd2;
  localparam logic       OP_ALLOC      = 1'b0;
  localparam logic       OP_FREE       = 1'b1;
  localparam int         CFG_BLOCK_BYTES = 0;
  localparam int         CFG_CHUNKS      = 1;
endpackage

>>> rtl/core/cfba_divider.sv
// ----------------------------------------------------------------------------
// cfba_divider
// restoring divider, one quotient bit per cycle, 18-bit dividend, 8-bit divisor
// ----------------------------------------------------------------------------
module cfba_divider import cfba_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [17:0] dividend,
  input  logic [7:0]  divisor,
  output logic        done,
  output logic [17:0] quotient,
  output logic [7:0]  remainder
);
  logic [17:0] q_r, q_nxt;
  logic [8:0]  rem_r, rem_nxt;
  logic [7:0]  dv_r, dv_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [8:0]  trial;

  // one shift and subtract step
  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; dv_nxt = dv_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r[7:0], q_r[17]};
    if (start) begin
      q_nxt = dividend; rem_nxt = '0; dv_nxt = divisor;
      cnt_nxt = 5'd18; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dv_r}) begin
        rem_nxt = trial - {1'b0, dv_r};
        q_nxt = {q_r[16:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[16:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; dv_r <= dv_nxt;
  end

  assign done = done_r;
  assign quotient = q_r;
  assign remainder = rem_r[7:0];
endmodule

>>> rtl/core/chunked_fixed_block_allocator.sv
// ----------------------------------------------------------------------------
// chunked_fixed_block_allocator
// fixed-size block allocator with one free list per chunk
// ----------------------------------------------------------------------------
// channel | direction | signals
// in      | input     | in_valid in_ready in_operation in_free_offset
// out     | output    | out_valid out_ready out_status out_chunk_index ...
// cfg     | input     | cfg_we cfg_index cfg_wdata
// allocate time is set by the chunk scan over the head memory (one chunk
// a cycle); free time is set by the divider. after reset a clearing pass
// over all BLOCKS_PER_CHUNK*MAX_CHUNKS link entries fills the link memory
// and chunk heads before the first transfer is taken.
// the result sits in an output register; one item is in work at a time.
module chunked_fixed_block_allocator import cfba_pkg::*; #(
  parameter int BLOCKS_PER_CHUNK = 64,
  parameter int MAX_CHUNKS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [17:0] in_free_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [3:0]  out_chunk_index,
  output logic [5:0]  out_block_index,
  output logic [17:0] out_block_offset,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata
);
  localparam int BW = $clog2(BLOCKS_PER_CHUNK);
  localparam int CW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int NW = $clog2(MAX_CHUNKS + 1);
  localparam int CNTW = $clog2(BLOCKS_PER_CHUNK + 1);
  localparam int DEPTH = BLOCKS_PER_CHUNK * MAX_CHUNKS;
  localparam int AW = $clog2(DEPTH);
  localparam int HW = 8 + CNTW;

  typedef enum logic [9:0] {
    S_INIT  = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_RREC  = 10'b0000000100,
    S_CREC  = 10'b0000001000,
    S_SCAN  = 10'b0000010000,
    S_LINK  = 10'b0000100000,
    S_ALLOC = 10'b0001000000,
    S_DIV   = 10'b0010000000,
    S_FREE  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  // link memory and chunk head memory
  logic [7:0]    link_mem [DEPTH];
  logic [HW-1:0] head_mem [MAX_CHUNKS];
  logic [7:0]    link_q;
  logic [HW-1:0] head_q;
  logic          lk_we, hd_we;
  logic [AW-1:0] lk_waddr, lk_raddr;
  logic [7:0]    lk_wdata;
  logic [CW-1:0] hd_waddr, hd_raddr;
  logic [HW-1:0] hd_wdata;

  always_ff @(posedge clk) begin
    if (lk_we) link_mem[lk_waddr] <= lk_wdata;
    link_q <= link_mem[lk_raddr];
  end
  always_ff @(posedge clk) begin
    if (hd_we) head_mem[hd_waddr] <= hd_wdata;
    head_q <= head_mem[hd_raddr];
  end

  logic [7:0]    bb_r;
  logic [4:0]    cu_r;
  logic [AW:0]   init_r, init_nxt;
  logic [CW-1:0] rc_r, rc_nxt, c_r, c_nxt;
  logic          rv_r, rv_nxt;
  logic [NW-1:0] i_r, i_nxt;
  logic [BW-1:0] b_r, b_nxt;
  logic [17:0]   off_r, off_nxt;
  logic [1:0]    st_r, st_nxt;
  logic [3:0]    oc_r, oc_nxt;
  logic [5:0]    ob_r, ob_nxt;
  logic [17:0]   oo_r, oo_nxt;
  logic [17:0]   prod_r, prod_nxt;
  logic          div_start;
  logic          div_done;
  logic [17:0]   quo;
  logic [7:0]    rem;
  logic [NW-1:0] n_act;
  logic [7:0]    hq_ff;
  logic [CNTW-1:0] hq_cnt;
  logic          hq_has;

  // effective chunk count
  assign n_act = (cu_r > 5'(MAX_CHUNKS)) ? NW'(MAX_CHUNKS) : NW'(cu_r);
  assign hq_ff  = head_q[HW-1:CNTW];
  assign hq_cnt = head_q[CNTW-1:0];
  assign hq_has = (hq_cnt != '0) && (32'(hq_ff) < BLOCKS_PER_CHUNK);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bb_r <= 8'd8; cu_r <= 5'd16;
    end else if (cfg_we) begin
      if (cfg_index == 1'(CFG_BLOCK_BYTES)) bb_r <= cfg_wdata;
      else cu_r <= cfg_wdata[4:0];
    end
  end

  cfba_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(off_r),
    .divisor(bb_r), .done(div_done), .quotient(quo), .remainder(rem)
  );

  always_comb begin
    state_nxt = state_r; init_nxt = init_r; rc_nxt = rc_r; rv_nxt = rv_r;
    c_nxt = c_r; i_nxt = i_r; b_nxt = b_r; off_nxt = off_r;
    st_nxt = st_r; oc_nxt = oc_r; ob_nxt = ob_r; oo_nxt = oo_r; prod_nxt = prod_r;
    lk_we = 1'b0; lk_waddr = init_r[AW-1:0]; lk_wdata = '0; lk_raddr = '0;
    hd_we = 1'b0; hd_waddr = '0; hd_wdata = '0; hd_raddr = c_r;
    div_start = 1'b0;
    unique case (state_r)
      // clearing pass
      S_INIT: begin
        lk_we = 1'b1;
        lk_wdata = 8'((32'(init_r) % BLOCKS_PER_CHUNK) + 1);
        hd_we = (32'(init_r) < MAX_CHUNKS);
        hd_waddr = init_r[CW-1:0];
        hd_wdata = {8'd0, CNTW'(BLOCKS_PER_CHUNK)};
        init_nxt = init_r + 1'b1;
        if (32'(init_r) == DEPTH - 1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          off_nxt = in_free_offset;
          if (in_operation == OP_ALLOC) begin
            if (rv_r && (NW'(rc_r) < n_act)) begin
              c_nxt = rc_r; hd_raddr = rc_r; state_nxt = S_RREC;
            end else begin
              c_nxt = '0; i_nxt = '0; state_nxt = S_SCAN;
              hd_raddr = '0;
            end
          end else begin
            i_nxt = '0;
            state_nxt = S_DIV;
          end
        end
      end
      S_RREC: state_nxt = S_CREC;
      S_CREC: begin
        if (hq_has) begin
          lk_raddr = AW'(32'(c_r) * BLOCKS_PER_CHUNK + 32'(hq_ff));
          b_nxt = hq_ff[BW-1:0]; state_nxt = S_LINK;
        end else begin
          c_nxt = '0; i_nxt = '0; hd_raddr = '0; state_nxt = S_SCAN;
        end
      end
      // chunk scan: head read of chunk c issued last cycle
      S_SCAN: begin
        if (i_r == '0) begin
          i_nxt = NW'(1);
          hd_raddr = '0;
          if (n_act == '0) begin
            st_nxt = ST_NO_SPACE; oc_nxt = '0; ob_nxt = '0; oo_nxt = '0;
            state_nxt = S_OUT;
          end
        end else if (hq_has) begin
          lk_raddr = AW'(32'(c_r) * BLOCKS_PER_CHUNK + 32'(hq_ff));
          b_nxt = hq_ff[BW-1:0]; state_nxt = S_LINK;
        end else if (i_r >= n_act) begin
          st_nxt = ST_NO_SPACE; oc_nxt = '0; ob_nxt = '0; oo_nxt = '0;
          state_nxt = S_OUT;
        end else begin
          c_nxt = CW'(i_r); hd_raddr = CW'(i_r); i_nxt = i_r + 1'b1;
        end
      end
      // keep the link read on the head block so it is still there next cycle
      S_LINK: begin
        prod_nxt = 18'(32'(c_r) * BLOCKS_PER_CHUNK + 32'(b_r));
        lk_raddr = AW'(32'(c_r) * BLOCKS_PER_CHUNK + 32'(b_r));
        hd_raddr = c_r;
        state_nxt = S_ALLOC;
      end
      S_ALLOC: begin
        hd_we = 1'b1; hd_waddr = c_r;
        hd_wdata = {link_q, hq_cnt - 1'b1};
        rc_nxt = c_r; rv_nxt = 1'b1;
        st_nxt = ST_OK; oc_nxt = 4'(c_r); ob_nxt = 6'(b_r);
        oo_nxt = 18'(prod_r * bb_r);
        state_nxt = S_OUT;
      end
      S_DIV: begin
        if (i_r == '0) begin
          div_start = 1'b1; i_nxt = NW'(1);
        end else if (div_done) begin
          i_nxt = '0;
          c_nxt = CW'(32'(quo) / BLOCKS_PER_CHUNK);
          hd_raddr = CW'(32'(quo) / BLOCKS_PER_CHUNK);
          b_nxt = BW'(32'(quo) % BLOCKS_PER_CHUNK);
          if (bb_r == 8'd0 || rem != 8'd0 ||
              32'(quo) >= 32'(n_act) * BLOCKS_PER_CHUNK) begin
            st_nxt = ST_BAD_OFFSET; oc_nxt = '0; ob_nxt = '0; oo_nxt = '0;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_FREE; prod_nxt = '0;
          end
        end
      end
      S_FREE: begin
        if (prod_r == '0) begin
          prod_nxt = 18'd1; hd_raddr = c_r;
        end else begin
          lk_we = 1'b1;
          lk_waddr = AW'(32'(c_r) * BLOCKS_PER_CHUNK + 32'(b_r));
          lk_wdata = hq_ff;
          hd_we = 1'b1; hd_waddr = c_r;
          hd_wdata = {8'(b_r),
                      (32'(hq_cnt) < BLOCKS_PER_CHUNK) ? hq_cnt + 1'b1 : hq_cnt};
          st_nxt = ST_OK; oc_nxt = 4'(c_r); ob_nxt = 6'(b_r); oo_nxt = off_r;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT; init_r <= '0; rv_r <= 1'b0; rc_r <= '0; i_r <= '0;
    end else begin
      state_r <= state_nxt; init_r <= init_nxt; rv_r <= rv_nxt; rc_r <= rc_nxt;
      i_r <= i_nxt;
    end
    c_r <= c_nxt; b_r <= b_nxt; off_r <= off_nxt; st_r <= st_nxt;
    oc_r <= oc_nxt; ob_r <= ob_nxt; oo_r <= oo_nxt; prod_r <= prod_nxt;
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_status = st_r;
  assign out_chunk_index = oc_r;
  assign out_block_index = ob_r;
  assign out_block_offset = oo_r;
endmodule

>>> rtl/core/cfba_checker.sv
// ----------------------------------------------------------------------------
// cfba_checker
// port-level checks of the block allocator
// ----------------------------------------------------------------------------
`include "chunked_fixed_block_allocator_assert.svh"
module cfba_checker import cfba_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [3:0]  out_chunk_index,
  input logic [5:0]  out_block_index,
  input logic [17:0] out_block_offset
);
  // one item in work: no transfer in while a result waits
  `CFBA_ASSERT_IMP(a_no_overlap, out_valid, !in_ready)
  // failed results carry zero fields
  `CFBA_ASSERT_IMP(a_err_zero, out_valid && out_status != ST_OK,
    out_chunk_index == 4'd0 && out_block_index == 6'd0 && out_block_offset == 18'd0)
  // status code is legal
  `CFBA_ASSERT_IMP(a_status, out_valid, out_status != 2'd3)
  // an accepted item never gets an immediate result
  `CFBA_ASSERT_NXT(a_latency, in_valid && in_ready, !out_valid)
endmodule

bind chunked_fixed_block_allocator cfba_checker u_cfba_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
  .out_chunk_index(out_chunk_index), .out_block_index(out_block_index),
  .out_block_offset(out_block_offset)
);

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the chunked fixed-size block allocator: a queued
// driver feeds allocate/free requests in bursts, a request-level allocator model
// predicts each result and a monitor compares every output transfer in order
// ----------------------------------------------------------------------------
module tb_top;
  import cfba_pkg::*;

  localparam int BPC       = 64;
  localparam int NCHUNK    = 16;
  localparam int CYC_LIMIT = 600000;
  localparam int SETTLE    = 60;

  typedef struct {
    logic        op;
    logic [17:0] offset;
  } req_t;

  typedef struct {
    logic [1:0]  status;
    logic [3:0]  chunk;
    logic [5:0]  block;
    logic [17:0] offset;
  } resp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_operation = 1'b0;
  logic [17:0] in_free_offset = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [3:0]  out_chunk_index;
  logic [5:0]  out_block_index;
  logic [17:0] out_block_offset;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_wdata = '0;

  chunked_fixed_block_allocator uut (.*);

  // allocator model state
  logic [7:0] link_mem [BPC*NCHUNK];
  int         head_blk [NCHUNK];
  int         free_cnt [NCHUNK];
  int         last_chunk;
  bit         last_chunk_ok;
  int         blk_bytes;
  int         chunk_cfg;
  int         live_offsets[$];

  req_t  pending_reqs[$];
  resp_t expected_resps[$];
  int    n_errors = 0;
  int    n_ok = 0, n_nospace = 0, n_bad = 0;
  int    cycle_cnt = 0;
  int    burst_left = 0, gap_left = 0;
  int    hold_req = 0, hold_ack = 0, hold_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void alloc_model_reset();
    for (int c = 0; c < NCHUNK; c++) begin
      for (int b = 0; b < BPC; b++) link_mem[c*BPC+b] = 8'(b + 1);
      head_blk[c] = 0;
      free_cnt[c] = BPC;
    end
    last_chunk = 0;
    last_chunk_ok = 0;
    blk_bytes = 8;
    chunk_cfg = 16;
  endfunction

  function automatic bit has_free(int c);
    return free_cnt[c] > 0 && head_blk[c] < BPC;
  endfunction

  // compute the result of one request and update the model
  function automatic resp_t alloc_predict(req_t r);
    resp_t res;
    int n, c, b, idx;
    longint lim;
    bit found;
    res = '{ST_OK, 4'd0, 6'd0, 18'd0};
    n = (chunk_cfg > NCHUNK) ? NCHUNK : chunk_cfg;
    found = 0;
    c = 0;
    if (r.op == OP_ALLOC) begin
      if (last_chunk_ok && last_chunk < n && has_free(last_chunk)) begin
        c = last_chunk;
        found = 1;
      end else begin
        for (int i = 0; i < n && !found; i++)
          if (has_free(i)) begin
            c = i;
            found = 1;
          end
      end
      if (!found) begin
        res.status = ST_NO_SPACE;
        return res;
      end
      last_chunk = c;
      last_chunk_ok = 1;
      b = head_blk[c];
      head_blk[c] = link_mem[c*BPC+b];
      free_cnt[c]--;
      res.chunk = 4'(c);
      res.block = 6'(b);
      res.offset = 18'((c*BPC + b) * blk_bytes);
      live_offsets.push_back(int'(res.offset));
    end else begin
      lim = longint'(n) * BPC * blk_bytes;
      if (blk_bytes == 0 || longint'(r.offset) >= lim ||
          (int'(r.offset) % blk_bytes) != 0)
      begin
        res.status = ST_BAD_OFFSET;
        return res;
      end
      idx = int'(r.offset) / blk_bytes;
      c = idx / BPC;
      b = idx % BPC;
      link_mem[c*BPC+b] = 8'(head_blk[c]);
      head_blk[c] = b;
      if (free_cnt[c] < BPC) free_cnt[c]++;
      res.chunk = 4'(c);
      res.block = 6'(b);
      res.offset = r.offset;
    end
    return res;
  endfunction

  // driver: bursts with random gaps, valid held until the transfer
  always @(posedge clk) begin
    req_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        expected_resps.push_back(alloc_predict('{in_operation, in_free_offset}));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          it = pending_reqs.pop_front();
          in_operation <= it.op;
          in_free_offset <= it.offset;
          in_valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 12) : 0;
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: long hold-off on request, otherwise alternating stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = 400;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= cycle_cnt[6] ? 1'b1 : ($urandom_range(0, 2) != 0);
    end
  end

  // monitor: compare each output transfer with the oldest expectation
  always @(posedge clk) begin
    resp_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_resps.size() == 0) begin
        $display("%0t: unexpected result status=%0d", $time, out_status);
        n_errors++;
      end else begin
        e = expected_resps.pop_front();
        if (out_status !== e.status || out_chunk_index !== e.chunk ||
            out_block_index !== e.block || out_block_offset !== e.offset) begin
          $display({"%0t: mismatch exp st=%0d ch=%0d blk=%0d off=%0d",
                    " act st=%0d ch=%0d blk=%0d off=%0d"},
                   $time, e.status, e.chunk, e.block, e.offset,
                   out_status, out_chunk_index, out_block_index, out_block_offset);
          n_errors++;
        end
        case (e.status)
          ST_OK:       n_ok++;
          ST_NO_SPACE: n_nospace++;
          default:     n_bad++;
        endcase
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYC_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               expected_resps.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic cfg_write(logic idx, int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= 8'(val);
    if (idx == 1'(CFG_BLOCK_BYTES)) blk_bytes = val & 8'hFF;
    else chunk_cfg = val & 5'h1F;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until all work is done; checked again after the settle time so a
  // request launched in the same step as the check is not missed
  task automatic wait_drained();
    while (pending_reqs.size() > 0 || expected_resps.size() > 0 || in_valid)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    while (pending_reqs.size() > 0 || expected_resps.size() > 0 || in_valid)
      @(posedge clk);
  endtask

  task automatic push_req(logic op, int off);
    pending_reqs.push_back('{op, 18'(off)});
  endtask

  // one random batch: alloc_pct percent allocations, the frees mostly of live blocks, some aligned and raw noise
  task automatic gen_batch(int cnt, int alloc_pct);
    int r, k, n;
    for (int i = 0; i < cnt; i++) begin
      n = (chunk_cfg > NCHUNK) ? NCHUNK : chunk_cfg;
      if ($urandom_range(0, 99) < alloc_pct) begin
        push_req(OP_ALLOC, $urandom_range(0, 262143));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65 && live_offsets.size() > 0) begin
          k = $urandom_range(0, live_offsets.size() - 1);
          push_req(OP_FREE, live_offsets[k]);
          live_offsets.delete(k);
        end else if (r < 85 && blk_bytes > 0 && n > 0) begin
          push_req(OP_FREE, blk_bytes * $urandom_range(0, n*BPC - 1));
        end else begin
          push_req(OP_FREE, $urandom_range(0, 262143));
        end
      end
    end
  endtask

  initial begin
    int bb_set[8] = '{1, 255, 0, 3, 8, 255, 17, 64};
    int ch_set[8] = '{1, 16, 4, 31, 0, 1, 2, 9};
    alloc_model_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, edges of offset range and alignment
    push_req(OP_ALLOC, 0);
    push_req(OP_ALLOC, 262143);
    push_req(OP_FREE, 0);
    push_req(OP_FREE, 0);
    push_req(OP_FREE, 3);
    push_req(OP_FREE, 8184);
    push_req(OP_FREE, 8192);
    push_req(OP_FREE, 261119);
    push_req(OP_FREE, 262143);
    push_req(OP_FREE, 131071);
    for (int i = 0; i < 6; i++) push_req(OP_ALLOC, 0);
    push_req(OP_FREE, 8);
    push_req(OP_FREE, 16);
    push_req(OP_ALLOC, 0);
    wait_drained();

    // every register written, including zero chunks and zero block size
    cfg_write(1'(CFG_CHUNKS), 0);
    push_req(OP_ALLOC, 0);
    push_req(OP_FREE, 0);
    wait_drained();
    cfg_write(1'(CFG_BLOCK_BYTES), 0);
    cfg_write(1'(CFG_CHUNKS), 2);
    push_req(OP_ALLOC, 0);
    push_req(OP_FREE, 0);
    wait_drained();

    // receiver holds off while the sender keeps offering
    cfg_write(1'(CFG_BLOCK_BYTES), 8);
    cfg_write(1'(CFG_CHUNKS), 16);
    gen_batch(30, 60);
    hold_req++;
    wait_drained();

    // random phases across settings, batches drained so frees see live blocks
    for (int p = 0; p < 8; p++) begin
      cfg_write(1'(CFG_BLOCK_BYTES), bb_set[p]);
      cfg_write(1'(CFG_CHUNKS), ch_set[p]);
      live_offsets.delete();
      for (int b = 0; b < 4; b++) begin
        gen_batch($urandom_range(8, 20), (b < 2) ? 75 : 40);
        wait_drained();
      end
    end

    $display("covered %0d ok, %0d no-space and %0d bad-offset results",
             n_ok, n_nospace, n_bad);
    $display("over eight block-size/chunk-count settings with idle and stall patterns");
    if (n_errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/cfba_pkg.sv
rtl/core/cfba_divider.sv
rtl/core/chunked_fixed_block_allocator.sv
rtl/core/cfba_checker.sv
sim/tb_top.sv
